// ===== rtl/threshold_error_diffusion_macros.svh =====
// assertion macros for the threshold error diffusion block
`ifndef THRESHOLD_ERROR_DIFFUSION_MACROS_SVH
`define THRESHOLD_ERROR_DIFFUSION_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TED_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ted_pkg.sv =====
// shared constants and types for the threshold error diffusion block
package ted_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int CNT_W      = COL_W + 1;
    localparam int BANK_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    localparam int PIX_W      = 8;
    localparam int THR_W      = 9;
    localparam int IMG_W_W    = 11;
    localparam int EXT_W      = (CNT_W > IMG_W_W) ? CNT_W : IMG_W_W;
    localparam int ERR_W      = 10;
    localparam int STORE_W    = 13;
    localparam int SUM_W      = 15;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 1'd1;

    localparam logic [THR_W-1:0]   THR_RESET   = 9'd128;
    localparam logic [IMG_W_W-1:0] WIDTH_RESET = 11'd640;

    localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
    localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

    typedef logic [COL_W-1:0]          t_col;
    typedef logic signed [ERR_W-1:0]   t_err;
    typedef logic signed [STORE_W-1:0] t_store;
    typedef logic [PIX_W-1:0]          t_pix;

endpackage

// ===== rtl/ted_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module ted_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 512
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/threshold_error_diffusion.sv =====
// floyd-steinberg error diffusion to a binary image, one pixel per clock while the output does not stall
// an accepted pixel passes the stage one register, then the output register (two-stage flow)
// throughput: one pixel per clock when the output does not stall; the loop that sets it is the left-neighbor
//   error feedback (add, divide by 16, threshold compare, subtract), closed within stage two
// reset (synchronous, active low): clears valids, column, error carries, sets first-row flag
//   and loads threshold 128 and width 640; the line store is left as is (no clearing pass)
module threshold_error_diffusion (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ted_pkg::t_pix                 i_pixel,
    input  logic                          i_start_of_frame,
    // binary pixel output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ted_pkg::t_pix                 o_binary_pixel,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ted_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ted_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import ted_pkg::*;

    // fixed weights in sixteenths, sized for the arithmetic they feed
    localparam logic signed [SUM_W-1:0]   W7_SUM   = SUM_W'(7);
    localparam logic signed [SUM_W-1:0]   RND_SUM  = SUM_W'(15);
    localparam logic signed [STORE_W-1:0] W5_ST    = STORE_W'(5);
    localparam logic signed [STORE_W-1:0] W3_ST    = STORE_W'(3);
    localparam logic signed [ERR_W:0]     WHITE_EX = (ERR_W+1)'(255);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [THR_W-1:0]   r_threshold;
    logic [IMG_W_W-1:0] r_image_width;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= THR_RESET;
            r_image_width <= WIDTH_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD:   r_threshold   <= i_cfg_data[THR_W-1:0];
                CFG_IMAGE_WIDTH: r_image_width <= i_cfg_data[IMG_W_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp width to 2..MAX_WIDTH and threshold to 1..256
    logic [EXT_W-1:0] width_ext;
    logic [CNT_W-1:0] width_eff;
    logic [THR_W-1:0] thr_eff;

    assign width_ext = EXT_W'(r_image_width);

    always_comb begin
        if (width_ext < EXT_W'(2)) begin
            width_eff = CNT_W'(2);
        end else if (width_ext > EXT_W'(MAX_WIDTH)) begin
            width_eff = CNT_W'(MAX_WIDTH);
        end else begin
            width_eff = CNT_W'(width_ext);
        end
    end

    always_comb begin
        if (r_threshold == '0) begin
            thr_eff = THR_W'(1);
        end else if (r_threshold > THR_W'(256)) begin
            thr_eff = THR_W'(256);
        end else begin
            thr_eff = r_threshold;
        end
    end

    // ------------------------------------------------------------------
    // handshake and pipeline control
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_out_valid;
    logic s1_adv;
    logic accept;

    // stage one moves into the output register when that register is free or draining
    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign accept     = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // stage one: column tracking and line store read
    // ------------------------------------------------------------------
    t_col r_col;
    logic r_first_row;
    t_col n_col;
    logic n_first_row;
    t_col col_base;
    t_col col_cur;
    logic first_cur;
    logic last_cur;

    // start of frame restarts at column zero of a first row
    assign col_base  = i_start_of_frame ? '0 : r_col;
    assign first_cur = i_start_of_frame || r_first_row;

    // a shrunk width mid-row lands the pixel on the new last column
    assign col_cur  = ({1'b0, col_base} >= width_eff) ? COL_W'(width_eff - CNT_W'(1)) : col_base;
    assign last_cur = ((CNT_W'(col_cur) + CNT_W'(1)) >= width_eff);

    assign n_col       = last_cur ? '0 : COL_W'(CNT_W'(col_cur) + CNT_W'(1));
    assign n_first_row = last_cur ? 1'b0 : first_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_first_row <= 1'b1;
        end else if (accept) begin
            r_col       <= n_col;
            r_first_row <= n_first_row;
        end
    end

    // stage one payload
    t_pix   r_s1_pixel;
    logic   r_s1_sof;
    t_col   r_s1_col;
    logic   r_s1_last;
    logic   r_s1_first;
    logic   r_s1_fwd_hit;
    t_store r_s1_fwd_data;

    // stage two write-back (driven below), needed here for forwarding
    logic   wr_a_en;
    logic   wr_b_en;
    t_col   wr_a_col;
    t_store err_a;
    t_store err_b;
    logic   fwd_a_hit;
    logic   fwd_b_hit;

    // the pixel ahead may write the entry this pixel reads at the same edge;
    // the ram returns old data then, so the new value is carried alongside
    assign fwd_a_hit = wr_a_en && (wr_a_col == col_cur);
    assign fwd_b_hit = wr_b_en && (r_s1_col == col_cur);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pixel    <= i_pixel;
            r_s1_sof      <= i_start_of_frame;
            r_s1_col      <= col_cur;
            r_s1_last     <= last_cur;
            r_s1_first    <= first_cur;
            r_s1_fwd_hit  <= fwd_a_hit || fwd_b_hit;
            r_s1_fwd_data <= fwd_a_hit ? err_a : err_b;
        end
    end

    // ------------------------------------------------------------------
    // line store: two banks split by column parity, so the two writes at
    // the end of a row (last column and the one before) never share a bank
    // ------------------------------------------------------------------
    logic [BANK_AW-1:0] rd_addr;
    logic [BANK_AW-1:0] wr_a_addr;
    logic [BANK_AW-1:0] wr_b_addr;
    logic               bank0_we;
    logic               bank1_we;
    logic [BANK_AW-1:0] bank0_waddr;
    logic [BANK_AW-1:0] bank1_waddr;
    t_store             bank0_wdata;
    t_store             bank1_wdata;
    t_store             bank0_rdata;
    t_store             bank1_rdata;

    assign rd_addr   = BANK_AW'(col_cur >> 1);
    assign wr_a_addr = BANK_AW'(wr_a_col >> 1);
    assign wr_b_addr = BANK_AW'(r_s1_col >> 1);

    // error for the column to the left goes to the opposite parity bank
    always_comb begin
        if (r_s1_col[0]) begin
            bank0_we    = wr_a_en;
            bank0_waddr = wr_a_addr;
            bank0_wdata = err_a;
            bank1_we    = wr_b_en;
            bank1_waddr = wr_b_addr;
            bank1_wdata = err_b;
        end else begin
            bank0_we    = wr_b_en;
            bank0_waddr = wr_b_addr;
            bank0_wdata = err_b;
            bank1_we    = wr_a_en;
            bank1_waddr = wr_a_addr;
            bank1_wdata = err_a;
        end
    end

    ted_ram #(
        .WIDTH (STORE_W),
        .DEPTH (BANK_DEPTH)
    ) u_bank0 (
        .i_clk     (i_clk),
        .i_wr_en   (bank0_we),
        .i_wr_addr (bank0_waddr),
        .i_wr_data (bank0_wdata),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (bank0_rdata)
    );

    ted_ram #(
        .WIDTH (STORE_W),
        .DEPTH (BANK_DEPTH)
    ) u_bank1 (
        .i_clk     (i_clk),
        .i_wr_en   (bank1_we),
        .i_wr_addr (bank1_waddr),
        .i_wr_data (bank1_wdata),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (bank1_rdata)
    );

    // ------------------------------------------------------------------
    // stage two: correct, threshold, spread error
    // ------------------------------------------------------------------
    t_err r_prev;
    t_err r_prev2;
    t_err prev_eff;
    t_err prev2_eff;
    t_store below;
    logic signed [SUM_W-1:0] total;
    logic signed [SUM_W-1:0] total_adj;
    logic signed [ERR_W:0]   corr;
    logic                    white;
    t_err                    err_cur;

    // start of frame drops carries left from the previous image
    assign prev_eff  = r_s1_sof ? '0 : r_prev;
    assign prev2_eff = r_s1_sof ? '0 : r_prev2;

    // first row has nothing from above
    always_comb begin
        if (r_s1_first) begin
            below = '0;
        end else if (r_s1_fwd_hit) begin
            below = r_s1_fwd_data;
        end else begin
            below = r_s1_col[0] ? bank1_rdata : bank0_rdata;
        end
    end

    assign total = $signed({{(SUM_W-PIX_W-4){1'b0}}, r_s1_pixel, 4'b0000})
                 + SUM_W'(prev_eff) * W7_SUM
                 + SUM_W'(below);

    // divide by 16 truncating toward zero
    assign total_adj = total[SUM_W-1] ? (total + RND_SUM) : total;
    assign corr      = (ERR_W+1)'(total_adj >>> 4);
    assign white     = (corr >= $signed({2'b00, thr_eff}));
    assign err_cur   = ERR_W'(white ? (corr - WHITE_EX) : corr);

    // down-left gets 3, down gets 5, down-right gets 1, summed over three pixels
    assign err_a = STORE_W'(prev2_eff) + STORE_W'(prev_eff) * W5_ST + STORE_W'(err_cur) * W3_ST;
    assign err_b = STORE_W'(prev_eff) + STORE_W'(err_cur) * W5_ST;

    assign wr_a_en  = s1_adv && (r_s1_col != '0);
    assign wr_a_col = r_s1_col - COL_W'(1);
    assign wr_b_en  = s1_adv && r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_prev2 <= '0;
        end else if (s1_adv) begin
            if (r_s1_last) begin
                r_prev  <= '0;
                r_prev2 <= '0;
            end else begin
                r_prev  <= err_cur;
                r_prev2 <= prev_eff;
            end
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    t_pix r_out_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_pixel <= white ? PIX_WHITE : PIX_BLACK;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_binary_pixel = r_out_pixel;

endmodule

// ===== rtl/ted_checker.sv =====
// port-level checker for the threshold error diffusion block, with its bind
`include "threshold_error_diffusion_macros.svh"

module ted_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input ted_pkg::t_pix o_binary_pixel
);

    // output is always pure black or pure white
    `TED_ASSERT_NOW(a_binary_levels, i_clk, i_rst_n, o_out_valid,
        o_binary_pixel == 8'd0 || o_binary_pixel == 8'd255, "non-binary output pixel")

    // an empty output register never back-pressures the input
    `TED_ASSERT_NOW(a_no_stall_when_empty, i_clk, i_rst_n, !o_out_valid,
        !o_in_stall, "input stalled with empty output")

    // a fresh result traces back to an accepted input transaction that went through stage one
    `TED_ASSERT_NOW(a_out_follows_in, i_clk, i_rst_n, $rose(o_out_valid),
        $past(i_in_valid && !o_in_stall, 2), "output without preceding input transaction")

    // a stalled result holds
    `TED_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_binary_pixel), "stalled output changed")

endmodule

bind threshold_error_diffusion ted_checker u_ted_checker (.*);

// ===== tb/testbench.sv =====
// directed and random test of the threshold error diffusion block against a behavioral dither model
`timescale 1ns / 1ps

module testbench;
    import ted_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RANDOM_ITEMS = 80;
    localparam int QUIET_TAIL   = 25;
    localparam int LONG_ROW     = 1030;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;

    typedef enum logic {STIM_PIXEL, STIM_CONFIG} t_stim_kind;
    typedef enum logic [1:0] {PAT_NOISE, PAT_FLAT, PAT_EXTREME, PAT_RAMP} t_pattern;

    // one row of the directed stimulus: a pixel transaction or a register update
    typedef struct {
        t_stim_kind            kind;
        t_pix                  pixel;
        logic                  sof;
        logic                  known;
        t_pix                  binary;
        logic                  thr_wr;
        logic [CFG_DATA_W-1:0] thr_data;
        logic                  width_wr;
        logic [CFG_DATA_W-1:0] width_data;
    } t_stim_row;

    // dut inputs, all driven to known values from time zero
    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_in_valid       = 1'b0;
    t_pix                  i_pixel          = '0;
    logic                  i_start_of_frame = 1'b0;
    logic                  i_out_stall      = 1'b0;
    logic                  i_cfg_valid      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_pix                  o_binary_pixel;
    logic                  o_cfg_ready;

    threshold_error_diffusion uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_pixel          (i_pixel),
        .i_start_of_frame (i_start_of_frame),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_binary_pixel   (o_binary_pixel),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // dither model state: next-row error in sixteenths plus the row walk
    // ------------------------------------------------------------------
    t_store                row_carry [MAX_WIDTH];
    bit                    row_written [MAX_WIDTH];
    int                    col_next      = 0;
    bit                    on_top_row    = 1'b1;
    int                    left_err      = 0;
    int                    left2_err     = 0;
    logic [THR_W-1:0]      thr_setting   = THR_RESET;
    logic [IMG_W_W-1:0]    width_setting = WIDTH_RESET;

    // results not yet seen on the output, oldest first
    t_pix                  expected_binary [$];
    t_pix                  oldest_binary;
    int                    error_count = 0;

    // idle pressure, changed per phase by the stimulus
    int                    gap_rate   = 0;
    int                    stall_rate = 0;
    int                    stall_left = 0;
    int                    idle_cycles = 0;

    t_stim_row             stim_rows [$];

    function automatic int clamped_width();
        int w;
        w = int'(width_setting);
        if (w < 2) w = 2;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    // a width change mid-row pins the column to the last one of the new width
    function automatic int clamped_col();
        int col;
        int w;
        col = col_next;
        w = clamped_width();
        if (col >= w) col = w - 1;
        return col;
    endfunction

    // true when the next pixel, without a start of frame, would read a line store
    // entry that no earlier row has filled in
    function automatic bit reads_unwritten();
        return !on_top_row && !row_written[clamped_col()];
    endfunction

    function automatic t_pix dither_predict(t_pix pix, logic sof);
        int   w;
        int   t;
        int   col;
        int   below;
        int   total;
        int   corr;
        int   err;
        t_pix bin;
        if (sof) begin
            col_next = 0;
            on_top_row = 1'b1;
            left_err = 0;
            left2_err = 0;
        end
        w = clamped_width();
        t = int'(thr_setting);
        if (t < 1) t = 1;
        if (t > 256) t = 256;
        col = clamped_col();

        // exact sum in sixteenths, then truncate toward zero
        below = on_top_row ? 0 : int'(row_carry[col]);
        total = 16 * int'(pix) + 7 * left_err + below;
        corr = total / 16;
        bin = (corr < t) ? PIX_BLACK : PIX_WHITE;
        err = corr - int'(bin);

        // down-left share lands one column back, together with the earlier pixels' shares
        if (col >= 1) begin
            row_carry[col - 1] = t_store'(left2_err + 5 * left_err + 3 * err);
            row_written[col - 1] = 1'b1;
        end
        if (col + 1 >= w) begin
            // row end: right-going error is dropped
            row_carry[col] = t_store'(left_err + 5 * err);
            row_written[col] = 1'b1;
            col_next = 0;
            on_top_row = 1'b0;
            left_err = 0;
            left2_err = 0;
        end else begin
            left2_err = left_err;
            left_err = err;
            col_next = col + 1;
        end
        return bin;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_pixel(t_pix pix, logic sof, logic known, t_pix bin);
        t_stim_row r;
        r = '{STIM_PIXEL, pix, sof, known, bin, 1'b0, '0, 1'b0, '0};
        stim_rows.push_back(r);
    endfunction

    function automatic void add_config(logic thr_wr, logic [CFG_DATA_W-1:0] thr_data,
                                       logic width_wr, logic [CFG_DATA_W-1:0] width_data);
        t_stim_row r;
        r = '{STIM_CONFIG, PIX_BLACK, 1'b0, 1'b0, PIX_BLACK, thr_wr, thr_data,
              width_wr, width_data};
        stim_rows.push_back(r);
    endfunction

    // one pixel transaction, with an optional idle burst ahead of it
    task automatic send_pixel(input t_pix pix, input logic sof, input logic known,
                              input t_pix typed);
        int   gap;
        t_pix predicted;
        gap = 0;
        if (gap_rate != 0 && $urandom_range(0, gap_rate) == 0) gap = $urandom_range(1, 12);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel <= pix;
        i_start_of_frame <= sof;
        do @(posedge i_clk); while (o_in_stall);
        predicted = dither_predict(pix, sof);
        expected_binary.push_back(known ? typed : predicted);
    endtask

    // register updates only once the pipeline has emptied
    task automatic write_config(input logic thr_wr, input logic [CFG_DATA_W-1:0] thr_data,
                                input logic width_wr, input logic [CFG_DATA_W-1:0] width_data);
        i_in_valid <= 1'b0;
        while (expected_binary.size() != 0) @(posedge i_clk);
        if (thr_wr) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_THRESHOLD;
            i_cfg_data <= thr_data;
            do @(posedge i_clk); while (!o_cfg_ready);
            thr_setting = thr_data[THR_W-1:0];
        end
        if (width_wr) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IMAGE_WIDTH;
            i_cfg_data <= width_data;
            do @(posedge i_clk); while (!o_cfg_ready);
            width_setting = width_data[IMG_W_W-1:0];
        end
        if (thr_wr || width_wr) i_cfg_valid <= 1'b0;
    endtask

    // extremes and out-of-range codes show up often, the rest sits mid-range
    function automatic logic [CFG_DATA_W-1:0] pick_threshold();
        case ($urandom_range(0, 9))
            0: return 11'd0;
            1: return 11'd1;
            2: return 11'd256;
            3: return 11'd511;
            4: return CFG_DATA_W'($urandom_range(0, 2047));
            default: return CFG_DATA_W'($urandom_range(40, 220));
        endcase
    endfunction

    // mostly narrow images so that many rows and row ends go by
    function automatic logic [CFG_DATA_W-1:0] pick_width();
        case ($urandom_range(0, 15))
            0: return CFG_DATA_W'($urandom_range(0, 1));
            1: return 11'd2;
            2: return 11'd1024;
            3: return 11'd2047;
            4: return CFG_DATA_W'($urandom_range(13, 2047));
            default: return CFG_DATA_W'($urandom_range(2, 12));
        endcase
    endfunction

    function automatic int pick_rate();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 2;
            2: return 5;
            default: return 12;
        endcase
    endfunction

    function automatic t_pix pick_pixel(t_pattern pat, t_pix level, int idx);
        int v;
        case (pat)
            PAT_NOISE: return t_pix'($urandom);
            PAT_FLAT: begin
                // flat gray with a little noise, the classic dither pattern
                v = int'(level) + int'($urandom_range(0, 8)) - 4;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return t_pix'(v);
            end
            PAT_EXTREME: return ($urandom_range(0, 1) != 0) ? PIX_WHITE : PIX_BLACK;
            default: return t_pix'(int'(level) + idx * 9);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // output side: random stall bursts, their length counted down in cycles
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_rate != 0 && $urandom_range(0, stall_rate) == 0) begin
            stall_left <= $urandom_range(0, 11);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // output check against the oldest waiting result
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_binary.size() == 0) begin
                $error("binary_pixel: unexpected output transaction, got %0d", o_binary_pixel);
                error_count++;
            end else begin
                oldest_binary = expected_binary.pop_front();
                if (o_binary_pixel !== oldest_binary) begin
                    $error("binary_pixel: expected %0d, got %0d", oldest_binary,
                           o_binary_pixel);
                    error_count++;
                end
            end
        end
    end

    // watchdog: too long without any transaction on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("** threshold_error_diffusion: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int       sent;
        int       run;
        logic     sof;
        t_pattern pat;
        t_pix     level;

        // after reset: threshold 128, width 640
        add_pixel(8'd0,   1'b1, 1'b1, PIX_BLACK);
        add_pixel(8'd255, 1'b0, 1'b1, PIX_WHITE);
        add_pixel(8'd127, 1'b0, 1'b1, PIX_BLACK);
        add_pixel(8'd255, 1'b0, 1'b0, PIX_BLACK);
        // start of frame drops the carried error, so 128 sits right on the threshold
        add_pixel(8'd128, 1'b1, 1'b1, PIX_WHITE);
        // threshold zero clamps to one, width zero clamps to two
        add_config(1'b1, 11'd0, 1'b1, 11'd0);
        add_pixel(8'd0,   1'b1, 1'b1, PIX_BLACK);
        add_pixel(8'd1,   1'b0, 1'b1, PIX_WHITE);
        add_pixel(8'd255, 1'b0, 1'b0, PIX_BLACK);
        add_pixel(8'd0,   1'b0, 1'b0, PIX_BLACK);
        add_pixel(8'd255, 1'b0, 1'b0, PIX_BLACK);
        add_pixel(8'd255, 1'b0, 1'b0, PIX_BLACK);
        // top codes clamp: threshold 256, width 1024
        add_config(1'b1, 11'd511, 1'b1, 11'd2047);
        add_pixel(8'd255, 1'b1, 1'b1, PIX_BLACK);
        add_pixel(8'd255, 1'b0, 1'b0, PIX_BLACK);
        add_config(1'b1, 11'd256, 1'b1, 11'd6);
        add_pixel(8'd200, 1'b1, 1'b0, PIX_BLACK);
        add_pixel(8'd50,  1'b0, 1'b0, PIX_BLACK);
        add_pixel(8'd90,  1'b0, 1'b0, PIX_BLACK);
        add_pixel(8'd255, 1'b0, 1'b0, PIX_BLACK);
        // width shrinks mid-row: the next pixel is past the new last column and ends the row
        add_config(1'b0, 11'd0, 1'b1, 11'd3);
        add_pixel(8'd100, 1'b0, 1'b0, PIX_BLACK);
        add_pixel(8'd30,  1'b0, 1'b0, PIX_BLACK);
        add_pixel(8'd220, 1'b0, 1'b0, PIX_BLACK);
        add_pixel(8'd140, 1'b0, 1'b0, PIX_BLACK);
        // start of frame in the middle of a frame
        add_pixel(8'd255, 1'b1, 1'b1, PIX_BLACK);
        add_config(1'b1, 11'd1, 1'b1, 11'd2);
        add_pixel(8'd0,   1'b1, 1'b1, PIX_BLACK);
        add_pixel(8'd255, 1'b0, 1'b0, PIX_BLACK);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_rate = 3;
        stall_rate = 4;
        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == STIM_CONFIG) begin
                write_config(stim_rows[i].thr_wr, stim_rows[i].thr_data,
                             stim_rows[i].width_wr, stim_rows[i].width_data);
            end else begin
                send_pixel(stim_rows[i].pixel, stim_rows[i].sof, stim_rows[i].known,
                           stim_rows[i].binary);
            end
        end

        // one full row at the widest setting and the start of the next
        gap_rate = 6;
        stall_rate = 6;
        write_config(1'b1, 11'd128, 1'b1, 11'd1024);
        for (int i = 0; i < LONG_ROW; i++) begin
            send_pixel(t_pix'($urandom), (i == 0), 1'b0, PIX_BLACK);
        end

        // random phases: new settings, idle pressure and picture content per phase
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) != 0) begin
                write_config(1'($urandom_range(0, 1)), pick_threshold(),
                             1'($urandom_range(0, 1)), pick_width());
            end
            gap_rate = pick_rate();
            stall_rate = pick_rate();
            pat = t_pattern'($urandom_range(0, 3));
            level = t_pix'($urandom);
            run = $urandom_range(10, 60);
            for (int i = 0; i < run && sent < RANDOM_ITEMS; i++) begin
                // the tail of the random test goes without idling on either side
                if (sent >= RANDOM_ITEMS - QUIET_TAIL) begin
                    gap_rate = 0;
                    stall_rate = 0;
                end
                // a frame restart is forced where the line store holds nothing yet
                sof = (i == 0 && $urandom_range(0, 1) != 0) || $urandom_range(0, 49) == 0
                      || reads_unwritten();
                send_pixel(pick_pixel(pat, level, i), sof, 1'b0, PIX_BLACK);
                sent++;
            end
        end

        i_in_valid <= 1'b0;
        while (expected_binary.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("** threshold_error_diffusion: PASSED **");
        end else begin
            $display("** threshold_error_diffusion: FAILED **");
        end
        $finish;
    end

endmodule
